>>> rtl/midi_track_event_parser_macros.svh
// ----------------------------------------------------------------------------
// MIDI track event parser assertion macros
// Shared property wrappers for the port checker, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_MACROS_SVH

// Implication property sampled on clk, disabled while reset is asserted
`define MTEP_ASSERT_IMPLY(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Plain boolean check sampled on clk, disabled while reset is asserted
`define MTEP_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

>>> rtl/mtep_pkg.sv
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Widths, status codes, parse phases and the records passed between stages.
// ----------------------------------------------------------------------------
package mtep_pkg;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 28;
  localparam int TICK_W    = 10;
  localparam int TIME_BITS = 32;
  localparam int EVT_TIME_W = 32;
  localparam int MULT_W    = TICK_W + LEN_W;

  // Status and meta codes
  localparam logic [BYTE_W-1:0] META_STATUS  = 8'hFF;
  localparam logic [BYTE_W-1:0] SYS_FIRST    = 8'hF0;
  localparam logic [BYTE_W-1:0] META_END     = 8'h2F;
  localparam logic [3:0]        SYS_NIBBLE   = 4'hF;
  localparam logic [3:0]        PROG_NIBBLE  = 4'hC;
  localparam logic [3:0]        PRESS_NIBBLE = 4'hD;

  localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1);

  // Parse phase of the current event
  typedef enum logic [2:0] {
    PH_DELTA  = 3'd0,
    PH_STATUS = 3'd1,
    PH_LEN    = 3'd2,
    PH_DATA   = 3'd3,
    PH_META   = 3'd4
  } mtep_phase_t;

  // Registered input request
  typedef struct packed {
    logic [BYTE_W-1:0] track_byte;
    logic              track_start;
  } mtep_item_t;

  // One parse result
  typedef struct packed {
    logic                  data_valid;
    logic [BYTE_W-1:0]     data_byte;
    logic [LEN_W-1:0]      data_index;
    logic                  event_done;
    logic                  event_kind;
    logic [BYTE_W-1:0]     status_byte;
    logic [BYTE_W-1:0]     meta_type;
    logic [LEN_W-1:0]      event_delta;
    logic [EVT_TIME_W-1:0] event_time;
  } mtep_result_t;

endpackage

>>> rtl/mtep_stream_if.sv
// ----------------------------------------------------------------------------
// MIDI track event parser channels
// Valid/ready interfaces for the track byte input and the event result output.
// ----------------------------------------------------------------------------
interface mtep_byte_if import mtep_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] track_byte;
  logic              track_start;

  modport source (output valid, output track_byte, output track_start, input ready);
  modport sink   (input valid, input track_byte, input track_start, output ready);
endinterface

interface mtep_event_if import mtep_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  data_valid;
  logic [BYTE_W-1:0]     data_byte;
  logic [LEN_W-1:0]      data_index;
  logic                  event_done;
  logic                  event_kind;
  logic [BYTE_W-1:0]     status_byte;
  logic [BYTE_W-1:0]     meta_type;
  logic [LEN_W-1:0]      event_delta;
  logic [EVT_TIME_W-1:0] event_time;

  modport source (
    output valid, output data_valid, output data_byte, output data_index,
    output event_done, output event_kind, output status_byte, output meta_type,
    output event_delta, output event_time, input ready
  );
  modport sink (
    input valid, input data_valid, input data_byte, input data_index,
    input event_done, input event_kind, input status_byte, input meta_type,
    input event_delta, input event_time, output ready
  );
endinterface

>>> rtl/mtep_in_stage.sv
// ----------------------------------------------------------------------------
// MIDI track event parser input stage
// Registers one track byte request and hands it to the parse step.
// ----------------------------------------------------------------------------
module mtep_in_stage import mtep_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  mtep_item_t in_item,
  input  logic       advance,
  output logic       item_valid,
  output mtep_item_t item
);

  logic       valid_r;
  logic       valid_nxt;
  mtep_item_t item_r;

  // Take a new request when empty or when the held one moves on
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> rtl/mtep_parse_core.sv
// ----------------------------------------------------------------------------
// MIDI track event parser core
// Holds the per-track parse state and decodes one track byte per step.
// ----------------------------------------------------------------------------
module mtep_parse_core import mtep_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata,
  input  logic              step,
  input  mtep_item_t        item,
  output mtep_result_t      result
);

  // State registers
  mtep_phase_t          phase_r,      phase_nxt;
  logic [BYTE_W-1:0]    run_status_r, run_status_nxt;
  logic [BYTE_W-1:0]    cur_status_r, cur_status_nxt;
  logic [BYTE_W-1:0]    cur_meta_r,   cur_meta_nxt;
  logic [LEN_W-1:0]     delta_r,      delta_nxt;
  logic [LEN_W-1:0]     rem_len_r,    rem_len_nxt;
  logic [LEN_W-1:0]     data_cnt_r,   data_cnt_nxt;
  logic [TIME_BITS-1:0] track_time_r, track_time_nxt;
  logic                 end_flag_r,   end_flag_nxt;
  logic [TICK_W-1:0]    tick_factor_r;

  // State as seen by this byte, after an optional track restart
  mtep_phase_t          phase_e;
  logic [BYTE_W-1:0]    run_status_e;
  logic [BYTE_W-1:0]    cur_status_e;
  logic [BYTE_W-1:0]    cur_meta_e;
  logic [LEN_W-1:0]     delta_e;
  logic [LEN_W-1:0]     rem_len_e;
  logic [LEN_W-1:0]     data_cnt_e;
  logic [TIME_BITS-1:0] track_time_e;
  logic                 end_flag_e;

  logic [BYTE_W-1:0]    cbyte;
  logic                 running;
  logic [BYTE_W-1:0]    status_sel;
  logic                 one_data;
  logic                 system_st;
  logic [LEN_W-1:0]     len_acc;
  logic [LEN_W-1:0]     rem_dec;
  logic [LEN_W-1:0]     delta_acc;
  logic [MULT_W-1:0]    delta_scaled;
  logic                 done;
  logic                 res_valid;
  logic [LEN_W-1:0]     res_index;

  assign cbyte = item.track_byte;

  // Apply track restart ahead of this byte
  assign phase_e      = item.track_start ? PH_DELTA : phase_r;
  assign run_status_e = item.track_start ? '0 : run_status_r;
  assign cur_status_e = item.track_start ? '0 : cur_status_r;
  assign cur_meta_e   = item.track_start ? '0 : cur_meta_r;
  assign delta_e      = item.track_start ? '0 : delta_r;
  assign rem_len_e    = item.track_start ? '0 : rem_len_r;
  assign data_cnt_e   = item.track_start ? '0 : data_cnt_r;
  assign track_time_e = item.track_start ? '0 : track_time_r;
  assign end_flag_e   = item.track_start ? 1'b0 : end_flag_r;

  // Byte classification and accumulators
  assign running    = !cbyte[BYTE_W-1];
  assign status_sel = running ? run_status_e : cbyte;
  assign one_data   = (status_sel[7:4] == PROG_NIBBLE) || (status_sel[7:4] == PRESS_NIBBLE);
  assign system_st  = (status_sel[7:4] == SYS_NIBBLE);
  assign len_acc    = {rem_len_e[LEN_W-8:0], cbyte[6:0]};
  assign rem_dec    = rem_len_e - LEN_W'(1);
  assign delta_acc  = {delta_e[LEN_W-8:0], cbyte[6:0]};

  // Scale delta time by the tick factor
  assign delta_scaled = MULT_W'(tick_factor_r) * MULT_W'(delta_acc);

  // Event completion
  always_comb begin
    unique case (phase_e)
      PH_STATUS: done = running && one_data;
      PH_LEN:    done = running && (len_acc == '0);
      PH_DATA:   done = (rem_dec == '0);
      default:   done = 1'b0;
    endcase
  end

  // Next parse phase
  always_comb begin
    unique case (phase_e)
      PH_STATUS: begin
        if (status_sel == META_STATUS) begin
          phase_nxt = PH_META;
        end else if (one_data) begin
          phase_nxt = running ? PH_DELTA : PH_DATA;
        end else if (system_st) begin
          phase_nxt = PH_LEN;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_META: phase_nxt = PH_LEN;
      PH_LEN: begin
        if (!running) begin
          phase_nxt = PH_LEN;
        end else if (len_acc == '0) begin
          phase_nxt = PH_DELTA;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: phase_nxt = done ? PH_DELTA : PH_DATA;
      default: phase_nxt = running ? PH_STATUS : PH_DELTA;
    endcase
  end

  // Datapath update and result fields
  always_comb begin
    run_status_nxt = run_status_e;
    cur_status_nxt = cur_status_e;
    cur_meta_nxt   = cur_meta_e;
    delta_nxt      = delta_e;
    rem_len_nxt    = rem_len_e;
    data_cnt_nxt   = data_cnt_e;
    track_time_nxt = track_time_e;
    end_flag_nxt   = end_flag_e;
    res_valid      = 1'b0;
    res_index      = '0;

    unique case (phase_e)
      PH_STATUS: begin
        cur_status_nxt = status_sel;
        if (running) begin
          res_valid    = 1'b1;
          res_index    = data_cnt_e;
          data_cnt_nxt = data_cnt_e + LEN_W'(1);
        end else begin
          // only channel statuses are kept as running status
          run_status_nxt = (cbyte < SYS_FIRST) ? cbyte : '0;
        end
        if (status_sel == META_STATUS) begin
          rem_len_nxt = rem_len_e;
        end else if (one_data) begin
          if (!running) begin
            rem_len_nxt = LEN_W'(1);
          end
        end else if (system_st) begin
          rem_len_nxt = '0;
        end else begin
          rem_len_nxt = running ? LEN_W'(1) : LEN_W'(2);
        end
      end
      PH_META: begin
        cur_meta_nxt = cbyte;
        end_flag_nxt = (cbyte == META_END);
        rem_len_nxt  = '0;
      end
      PH_LEN: begin
        rem_len_nxt = len_acc;
      end
      PH_DATA: begin
        res_valid    = 1'b1;
        res_index    = data_cnt_e;
        data_cnt_nxt = data_cnt_e + LEN_W'(1);
        rem_len_nxt  = rem_dec;
      end
      default: begin
        delta_nxt = delta_acc;
        if (running) begin
          track_time_nxt = track_time_e + TIME_BITS'(delta_scaled);
        end
      end
    endcase

    result.data_valid  = res_valid;
    result.data_byte   = res_valid ? cbyte : '0;
    result.data_index  = res_index;
    result.event_done  = done;
    result.event_kind  = done && end_flag_nxt;
    result.status_byte = cur_status_nxt;
    result.meta_type   = cur_meta_nxt;
    result.event_delta = delta_nxt;
    result.event_time  = EVT_TIME_W'(track_time_nxt);

    // Drop per-event state once the event completes
    if (done) begin
      cur_status_nxt = '0;
      cur_meta_nxt   = '0;
      delta_nxt      = '0;
      rem_len_nxt    = '0;
      data_cnt_nxt   = '0;
      end_flag_nxt   = 1'b0;
    end
  end

  // Advance parse state on each step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_DELTA;
      run_status_r <= '0;
      cur_status_r <= '0;
      cur_meta_r   <= '0;
      delta_r      <= '0;
      rem_len_r    <= '0;
      data_cnt_r   <= '0;
      track_time_r <= '0;
      end_flag_r   <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      run_status_r <= run_status_nxt;
      cur_status_r <= cur_status_nxt;
      cur_meta_r   <= cur_meta_nxt;
      delta_r      <= delta_nxt;
      rem_len_r    <= rem_len_nxt;
      data_cnt_r   <= data_cnt_nxt;
      track_time_r <= track_time_nxt;
      end_flag_r   <= end_flag_nxt;
    end
  end

  // Tick factor register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_factor_r <= TICK_RESET;
    end else if (cfg_we) begin
      tick_factor_r <= cfg_wdata;
    end
  end

endmodule

>>> rtl/mtep_out_stage.sv
// ----------------------------------------------------------------------------
// MIDI track event parser output stage
// Result register with valid/ready toward the event consumer.
// ----------------------------------------------------------------------------
module mtep_out_stage import mtep_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load_valid,
  output logic         load_ready,
  input  mtep_result_t load_data,
  output logic         out_valid,
  input  logic         out_ready,
  output mtep_result_t out_data
);

  logic         valid_r;
  logic         valid_nxt;
  mtep_result_t data_r;

  // Accept a new result when empty or when the held one is taken
  assign load_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load_valid && load_ready) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> rtl/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// MIDI track event parser
// Splits a standard MIDI track into events, a byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Takes one track byte per cycle while the output is not stalled and returns
// one result per byte, in order. A byte sits in the input register, then one
// step decodes it against the parse state (delta time, status with running
// status, length, data) and loads the result register; the delta time scaled
// by tick_factor is added to the track time in that same step, and that
// 10 x 28 bit multiply-add sets the cycle time. track_start restarts the track
// before its byte. Write tick_factor through cfg_we/cfg_wdata only while no
// request is in flight; it resets to 1.
module midi_track_event_parser import mtep_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata,
  mtep_byte_if.sink         in_bus,
  mtep_event_if.source      out_bus
);

  mtep_item_t   in_item;
  mtep_item_t   item;
  logic         item_valid;
  logic         load_ready;
  logic         advance;
  mtep_result_t step_result;
  mtep_result_t out_data;

  assign in_item.track_byte  = in_bus.track_byte;
  assign in_item.track_start = in_bus.track_start;

  // Step the parser when a byte is held and the result register has room
  assign advance = item_valid && load_ready;

  mtep_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  mtep_parse_core u_parse_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (item),
    .result    (step_result)
  );

  mtep_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (item_valid),
    .load_ready (load_ready),
    .load_data  (step_result),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_data   (out_data)
  );

  assign out_bus.data_valid  = out_data.data_valid;
  assign out_bus.data_byte   = out_data.data_byte;
  assign out_bus.data_index  = out_data.data_index;
  assign out_bus.event_done  = out_data.event_done;
  assign out_bus.event_kind  = out_data.event_kind;
  assign out_bus.status_byte = out_data.status_byte;
  assign out_bus.meta_type   = out_data.meta_type;
  assign out_bus.event_delta = out_data.event_delta;
  assign out_bus.event_time  = out_data.event_time;

endmodule

>>> rtl/mtep_checker.sv
// ----------------------------------------------------------------------------
// MIDI track event parser port checker
// Watches the result channel of the top level for parse and handshake slips.
// ----------------------------------------------------------------------------
`include "midi_track_event_parser_macros.svh"

module mtep_checker import mtep_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  data_valid,
  input logic [BYTE_W-1:0]     data_byte,
  input logic [LEN_W-1:0]      data_index,
  input logic                  event_done,
  input logic                  event_kind,
  input logic [BYTE_W-1:0]     status_byte,
  input logic [BYTE_W-1:0]     meta_type,
  input logic [EVT_TIME_W-1:0] event_time
);

  // A stalled result holds
  `MTEP_ASSERT_IMPLY(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(data_index) && $stable(event_time) && $stable(event_done), "result changed while stalled")

  // Non-data results carry a zero payload
  `MTEP_ASSERT_ALWAYS(a_idle_payload, !out_valid || data_valid || (data_byte == '0 && data_index == '0), "payload set without data_valid")

  // End of track is only flagged on a completed event
  `MTEP_ASSERT_ALWAYS(a_kind_done, !out_valid || !event_kind || event_done, "event_kind without event_done")

  // End of track comes only from the end-of-track meta event
  `MTEP_ASSERT_ALWAYS(a_kind_meta, !out_valid || !event_kind || (status_byte == META_STATUS && meta_type == META_END), "event_kind on a non end-of-track event")

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .data_valid  (out_bus.data_valid),
  .data_byte   (out_bus.data_byte),
  .data_index  (out_bus.data_index),
  .event_done  (out_bus.event_done),
  .event_kind  (out_bus.event_kind),
  .status_byte (out_bus.status_byte),
  .meta_type   (out_bus.meta_type),
  .event_time  (out_bus.event_time)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI track event parser testbench
// Feeds well-formed track events with random content, noise bytes and track
// restarts through the byte channel. Each accepted request is run through a
// local parser model, and every result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import mtep_pkg::*;

  localparam int          CLK_PERIOD    = 10;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          HOLD_CYCLES   = 150;
  localparam int          SEGMENT_BYTES = 240;
  localparam int          TAIL_CYCLES   = 8;
  localparam logic [3:0]  CHAN_FIRST_HI = 4'h8;
  localparam logic [3:0]  CHAN_LAST_HI  = 4'hE;
  localparam logic [7:0]  ST_NOTE_ON    = 8'h90;
  localparam logic [7:0]  ST_PROGRAM    = {PROG_NIBBLE, 4'h5};

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [TICK_W-1:0] cfg_wdata;

  mtep_byte_if  in_ch ();
  mtep_event_if out_ch ();

  midi_track_event_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_bus    (in_ch),
    .out_bus   (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Parser model state
  mtep_phase_t          trk_phase;
  logic [BYTE_W-1:0]    trk_running;
  logic [BYTE_W-1:0]    trk_status;
  logic [BYTE_W-1:0]    trk_meta;
  logic [LEN_W-1:0]     trk_delta;
  logic [LEN_W-1:0]     trk_remain;
  logic [LEN_W-1:0]     trk_count;
  logic [TIME_BITS-1:0] trk_time;
  logic                 trk_end;
  logic [TICK_W-1:0]    trk_tick;

  mtep_result_t expected_events[$];
  int unsigned  mismatch_count = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  cycle_count = 0;
  bit           next_start = 1'b0;
  bit           tx_stall_on = 1'b1;
  bit           rx_stall_on = 1'b1;
  bit           hold_request = 1'b0;

  function automatic void clear_event_state();
    trk_phase  = PH_DELTA;
    trk_status = '0;
    trk_meta   = '0;
    trk_delta  = '0;
    trk_remain = '0;
    trk_count  = '0;
    trk_end    = 1'b0;
  endfunction

  function automatic void clear_track_state();
    clear_event_state();
    trk_running = '0;
    trk_time    = '0;
  endfunction

  // Advance the parser model by one track byte and build its result
  function automatic mtep_result_t predict_event_byte(input logic [7:0] c, input logic start);
    mtep_result_t     r;
    logic             running;
    logic             valid;
    logic             done;
    logic [LEN_W-1:0] idx;
    logic [63:0]      prod;
    valid = 1'b0;
    done  = 1'b0;
    idx   = '0;
    if (start) clear_track_state();
    case (trk_phase)
      PH_STATUS: begin
        running = ~c[7];
        if (running) begin
          trk_status = trk_running;
          valid      = 1'b1;
          idx        = trk_count;
          trk_count  = trk_count + 1'b1;
        end else begin
          trk_status  = c;
          trk_running = (c < SYS_FIRST) ? c : '0;
        end
        if (trk_status == META_STATUS) begin
          trk_phase = PH_META;
        end else if (trk_status[7:4] == PROG_NIBBLE || trk_status[7:4] == PRESS_NIBBLE) begin
          if (running) begin
            done = 1'b1;
          end else begin
            trk_remain = LEN_W'(1);
            trk_phase  = PH_DATA;
          end
        end else if (trk_status[7:4] == SYS_NIBBLE) begin
          trk_remain = '0;
          trk_phase  = PH_LEN;
        end else begin
          trk_remain = running ? LEN_W'(1) : LEN_W'(2);
          trk_phase  = PH_DATA;
        end
      end
      PH_META: begin
        trk_meta   = c;
        trk_end    = (c == META_END);
        trk_remain = '0;
        trk_phase  = PH_LEN;
      end
      PH_LEN: begin
        trk_remain = {trk_remain[LEN_W-8:0], c[6:0]};
        if (!c[7]) begin
          if (trk_remain == '0) done = 1'b1;
          else trk_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        valid      = 1'b1;
        idx        = trk_count;
        trk_count  = trk_count + 1'b1;
        trk_remain = trk_remain - 1'b1;
        if (trk_remain == '0) done = 1'b1;
      end
      default: begin
        trk_delta = {trk_delta[LEN_W-8:0], c[6:0]};
        if (!c[7]) begin
          prod      = 64'(trk_tick) * 64'(trk_delta);
          trk_time  = trk_time + prod[TIME_BITS-1:0];
          trk_phase = PH_STATUS;
        end
      end
    endcase
    r.data_valid  = valid;
    r.data_byte   = valid ? c : '0;
    r.data_index  = valid ? idx : '0;
    r.event_done  = done;
    r.event_kind  = done ? trk_end : 1'b0;
    r.status_byte = trk_status;
    r.meta_type   = trk_meta;
    r.event_delta = trk_delta;
    r.event_time  = EVT_TIME_W'(trk_time);
    if (done) clear_event_state();
    return r;
  endfunction

  function automatic int unsigned draw_gap(input bit on);
    if (!on || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Offer one track byte, hold it until accepted, then queue its prediction
  task automatic send_track_byte(input logic [7:0] b);
    int unsigned gap;
    gap = draw_gap(tx_stall_on);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.track_byte  <= b;
    in_ch.track_start <= next_start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_events.push_back(predict_event_byte(b, next_start));
    next_start = 1'b0;
    bytes_sent++;
  endtask

  // Drop valid and wait until every queued request has come back
  task automatic drain_requests();
    in_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_tick_factor(input logic [TICK_W-1:0] value);
    drain_requests();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    trk_tick = value;
  endtask

  // Send a value as a minimal variable-length quantity
  task automatic send_vlq(input int unsigned v);
    int n;
    n = 1;
    while (n < 4 && (v >> (7 * n)) != 0) n++;
    for (int i = n - 1; i >= 0; i--)
      send_track_byte({(i > 0), 7'(v >> (7 * i))});
  endtask

  // One well-formed event with random delta, kind and content
  task automatic send_random_event();
    int unsigned       dval;
    int unsigned       len;
    int unsigned       ndata;
    logic [BYTE_W-1:0] live_running;
    logic [BYTE_W-1:0] st;
    bit                omit;
    // Resync with a track restart when left mid-event, and sometimes at random
    if (trk_phase != PH_DELTA || $urandom_range(0, 39) == 0) next_start = 1'b1;
    live_running = next_start ? '0 : trk_running;
    case ($urandom_range(0, 3))
      0: dval = 0;
      1: dval = $urandom_range(0, 127);
      2: dval = $urandom_range(0, 16383);
      default: dval = $urandom_range(0, 28'hFFFFFFF);
    endcase
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 200) : $urandom_range(0, 4);
    send_vlq(dval);
    case ($urandom_range(0, 9))
      6, 7: begin
        send_track_byte(8'($urandom_range(SYS_FIRST, META_STATUS - 1)));
        send_vlq(len);
        repeat (len) send_track_byte(8'($urandom));
      end
      8, 9: begin
        send_track_byte(META_STATUS);
        send_track_byte(($urandom_range(0, 3) == 0) ? META_END : 8'($urandom));
        send_vlq(len);
        repeat (len) send_track_byte(8'($urandom));
      end
      default: begin
        // Channel message, sometimes leaning on running status
        omit = $urandom_range(0, 1) && (live_running != '0 || $urandom_range(0, 3) == 0);
        if (omit) begin
          st = live_running;
        end else begin
          st = {4'($urandom_range(CHAN_FIRST_HI, CHAN_LAST_HI)), 4'($urandom)};
          send_track_byte(st);
        end
        ndata = (st[7:4] == PROG_NIBBLE || st[7:4] == PRESS_NIBBLE) ? 1 : 2;
        repeat (ndata) send_track_byte({1'b0, 7'($urandom)});
      end
    endcase
  endtask

  task automatic test_channel_events();
    // Note on with status, then the same under running status
    next_start = 1'b1;
    send_track_byte(8'h00);
    send_track_byte(ST_NOTE_ON);
    send_track_byte(8'h3C);
    send_track_byte(8'h7F);
    send_track_byte(8'h00);
    send_track_byte(8'h40);
    send_track_byte(8'h00);
    // Program change, then running status completing in the status slot
    send_track_byte(8'h00);
    send_track_byte(ST_PROGRAM);
    send_track_byte(8'h10);
    send_track_byte(8'h00);
    send_track_byte(8'h22);
  endtask

  task automatic test_meta_and_sysex();
    // Zero-length end of track, which also cancels running status
    send_track_byte(8'h00);
    send_track_byte(META_STATUS);
    send_track_byte(META_END);
    send_track_byte(8'h00);
    // Data byte with no running status: two-byte message with status zero
    send_track_byte(8'h00);
    send_track_byte(8'h55);
    send_track_byte(8'h11);
  endtask

  task automatic test_overlong_values();
    // Five-byte delta wraps at 28 bits
    repeat (4) send_track_byte(8'hFF);
    send_track_byte(8'h7F);
    // Sysex length that wraps to zero completes on its last length byte
    send_track_byte(SYS_FIRST);
    send_track_byte(8'h90);
    repeat (3) send_track_byte(8'h80);
    send_track_byte(8'h00);
  endtask

  task automatic test_backpressure();
    // Hold the receiver off while the sender keeps offering requests
    drain_requests();
    tx_stall_on  = 1'b0;
    hold_request = 1'b1;
    repeat (5) send_random_event();
    drain_requests();
    tx_stall_on = 1'b1;
  endtask

  task automatic test_random_stream();
    logic [TICK_W-1:0] tick_plan[5];
    int unsigned       seg_start;
    tick_plan = '{10'h3FF, 10'($urandom_range(2, 1022)), 10'h000, TICK_RESET,
                  10'($urandom_range(2, 1022))};
    foreach (tick_plan[i]) begin
      set_tick_factor(tick_plan[i]);
      seg_start = bytes_sent;
      while (bytes_sent - seg_start < SEGMENT_BYTES) begin
        if ($urandom_range(0, 19) == 0) begin
          tx_stall_on = 1'($urandom_range(0, 1));
          rx_stall_on = 1'($urandom_range(0, 1));
        end
        if ($urandom_range(0, 9) == 0) begin
          // Noise: raw bytes, some with a track restart
          repeat ($urandom_range(1, 4)) begin
            next_start = ($urandom_range(0, 7) == 0);
            send_track_byte(8'($urandom));
          end
        end else begin
          send_random_event();
        end
      end
    end
  endtask

  // Result receiver: random stalls per result, one long hold on request
  initial begin : result_sink
    int unsigned gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        gap = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        gap = draw_gap(rx_stall_on);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    mtep_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_events.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no pending request, expected none, actual status %0h",
                 $time, out_ch.status_byte);
      end else begin
        want = expected_events.pop_front();
        check_field("data_valid",  32'(want.data_valid),  32'(out_ch.data_valid));
        check_field("data_byte",   32'(want.data_byte),   32'(out_ch.data_byte));
        check_field("data_index",  32'(want.data_index),  32'(out_ch.data_index));
        check_field("event_done",  32'(want.event_done),  32'(out_ch.event_done));
        check_field("event_kind",  32'(want.event_kind),  32'(out_ch.event_kind));
        check_field("status_byte", 32'(want.status_byte), 32'(out_ch.status_byte));
        check_field("meta_type",   32'(want.meta_type),   32'(out_ch.meta_type));
        check_field("event_delta", 32'(want.event_delta), 32'(out_ch.event_delta));
        check_field("event_time",  32'(want.event_time),  32'(out_ch.event_time));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : test_sequence
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.track_byte  <= '0;
    in_ch.track_start <= 1'b0;
    clear_track_state();
    trk_tick = TICK_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_channel_events();
    test_meta_and_sysex();
    test_overlong_values();
    test_backpressure();
    test_random_stream();
    drain_requests();
    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
